@@ rtl/core/smtp_rcc_pkg.sv @@
package smtp_rcc_pkg;

	// Verdict codes carried in the result transaction
	typedef enum logic [1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_MISMATCH  = 2'd1,
		VERDICT_TOO_LARGE = 2'd2,
		VERDICT_IO_ERROR  = 2'd3
	} verdict_t;

	// Configuration register indexes
	localparam logic [1:0] REG_EXPECTED_CODE  = 2'd0;
	localparam logic [1:0] REG_MAX_LINE_BYTES = 2'd1;

	// Register reset values
	localparam logic [9:0]  EXPECTED_CODE_RST  = 10'd250;
	localparam logic [11:0] MAX_LINE_BYTES_RST = 12'd1023;

	// Characters
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH  = 8'h2d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;

	// Length of the code plus separator
	localparam logic [11:0] PREFIX_LEN = 12'd4;

	// Input item: failure flag and received byte
	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} item_t;

	// Expected code as three ASCII characters, hundreds first
	typedef struct packed {
		logic [7:0] hund;
		logic [7:0] tens;
		logic [7:0] ones;
	} code_chars_t;

	// Result of one step of the line checker
	typedef struct packed {
		logic     valid;
		verdict_t verdict;
	} line_res_t;

endpackage

@@ rtl/core/smtp_rcc_digits.sv @@
module smtp_rcc_digits (
	input  logic [9:0]                code,
	output smtp_rcc_pkg::code_chars_t chars
);
	import smtp_rcc_pkg::*;

	logic [3:0] hund;
	logic [6:0] rem_h;
	logic [3:0] tens;
	logic [3:0] ones;

	// Decimal split by threshold compares; hundreds digit may reach ten
	always_comb begin
		hund = '0;
		for (int k = 1; k <= 10; k++) begin
			if (code >= 10'(100 * k)) hund = 4'(k);
		end
		rem_h = 7'(code - 10'(hund) * 10'd100);
		tens = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_h >= 7'(10 * k)) tens = 4'(k);
		end
		ones = 4'(rem_h - 7'(tens) * 7'd10);
	end

	assign chars.hund = CHAR_0 + 8'(hund);
	assign chars.tens = CHAR_0 + 8'(tens);
	assign chars.ones = CHAR_0 + 8'(ones);

endmodule

@@ rtl/core/smtp_rcc_line.sv @@
module smtp_rcc_line (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  smtp_rcc_pkg::item_t       item,
	input  smtp_rcc_pkg::code_chars_t code_chars,
	input  logic [11:0]               max_line_bytes,
	output smtp_rcc_pkg::line_res_t   res
);
	import smtp_rcc_pkg::*;

	logic [11:0] line_count_q, line_count_d;
	logic        prefix_good_q, prefix_good_d;
	logic        final_marker_q, final_marker_d;
	logic        overflowed_q, overflowed_d;
	logic [7:0]  exp_char;

	// Character expected at the current prefix position
	always_comb begin
		case (line_count_q[1:0])
			2'd0:    exp_char = code_chars.hund;
			2'd1:    exp_char = code_chars.tens;
			default: exp_char = code_chars.ones;
		endcase
	end

	// Per-byte line update and verdict
	always_comb begin
		line_count_d   = line_count_q;
		prefix_good_d  = prefix_good_q;
		final_marker_d = final_marker_q;
		overflowed_d   = overflowed_q;
		res.valid      = 1'b0;
		res.verdict    = VERDICT_OK;
		if (item.kind) begin
			// read failure ends the reply
			res.valid   = 1'b1;
			res.verdict = overflowed_q ? VERDICT_TOO_LARGE : VERDICT_IO_ERROR;
		end else if (item.byte_value == CHAR_LF) begin
			res.valid = 1'b1;
			if (overflowed_q) begin
				res.verdict = VERDICT_TOO_LARGE;
			end else if (!prefix_good_q || line_count_q < PREFIX_LEN) begin
				res.verdict = VERDICT_MISMATCH;
			end else if (final_marker_q) begin
				res.verdict = VERDICT_OK;
			end else begin
				// good continuation line
				res.valid = 1'b0;
			end
		end else if (!overflowed_q) begin
			if (line_count_q >= max_line_bytes) begin
				overflowed_d = 1'b1;
			end else begin
				if (line_count_q < 12'd3) begin
					if (item.byte_value != exp_char) prefix_good_d = 1'b0;
				end else if (line_count_q == 12'd3) begin
					if (item.byte_value == CHAR_SPACE) begin
						final_marker_d = 1'b1;
					end else if (item.byte_value != CHAR_DASH) begin
						prefix_good_d = 1'b0;
					end
				end
				line_count_d = line_count_q + 12'd1;
			end
		end
		// newline and failure both start a fresh line
		if (item.kind || item.byte_value == CHAR_LF) begin
			line_count_d   = '0;
			prefix_good_d  = 1'b1;
			final_marker_d = 1'b0;
			overflowed_d   = 1'b0;
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q   <= '0;
			prefix_good_q  <= 1'b1;
			final_marker_q <= 1'b0;
			overflowed_q   <= 1'b0;
		end else if (step) begin
			line_count_q   <= line_count_d;
			prefix_good_q  <= prefix_good_d;
			final_marker_q <= final_marker_d;
			overflowed_q   <= overflowed_d;
		end
	end

endmodule

@@ rtl/core/smtp_reply_code_checker_core.sv @@
// Channel   Dir  Signals                       Contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser  received byte / read failure
// m_*       out  m_tvalid m_tready m_tdata     verdict
// cfg_*     in   cfg_wr_en cfg_index cfg_data  register writes, no read-back
//
// One input transaction per cycle sustained while the output is not stalled;
// a transaction is registered in the input register, checked against the line
// state and any verdict lands in the output register, which drives m_tvalid.
// Reset is asynchronous (arst_n low) and loads the code 250 and length 1023.
// A stall on m_tready holds the input register; s_tready drops only while
// both the input and output registers are full.
module smtp_reply_code_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [1:0] verdict, [7:2] zero
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import smtp_rcc_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	code_chars_t chars_q;
	code_chars_t chars_wr;
	code_chars_t chars_rst;
	logic [11:0] max_line_bytes_q;
	line_res_t   res;
	logic        res_valid_q;
	verdict_t    res_verdict_q;

	// Configuration: code is stored as its ASCII digits
	smtp_rcc_digits u_digits_wr (
		.code  (cfg_data[9:0]),
		.chars (chars_wr)
	);

	smtp_rcc_digits u_digits_rst (
		.code  (EXPECTED_CODE_RST),
		.chars (chars_rst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q          <= chars_rst;
			max_line_bytes_q <= MAX_LINE_BYTES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_EXPECTED_CODE:  chars_q <= chars_wr;
				REG_MAX_LINE_BYTES: max_line_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= s_tuser;
			item_s1.byte_value <= s_tdata;
		end
	end

	// Line checker
	smtp_rcc_line u_line (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.item           (item_s1),
		.code_chars     (chars_q),
		.max_line_bytes (max_line_bytes_q),
		.res            (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= res.valid;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) res_verdict_q <= res.verdict;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {6'd0, res_verdict_q};

endmodule

@@ rtl/core/smtp_rcc_checker.sv @@
module smtp_rcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        cfg_wr_en,
	input logic [1:0]  cfg_index,
	input logic [11:0] cfg_data
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// No result while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// A new result follows an accepted input transaction
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without input transaction");

	// A read failure gives too_large or io_error once the output is free
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) ##1 m_tready |=> m_tvalid && m_tdata[1])
		else $error("read failure verdict missing");

endmodule

bind smtp_reply_code_checker_core smtp_rcc_checker u_chk (.*);
